// File: rtl/efc_pkg.sv
`timescale 1ns / 1ps

package efc_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 4;

   localparam int unsigned FLOOR_W  = 2;
   localparam int unsigned FLOORS   = 4;
   localparam int unsigned SEG_W    = 7;
   localparam int unsigned PCOUNT_W = 3;

   typedef logic [FLOOR_W-1:0] floor_type;
   typedef logic [FLOORS-1:0]  floor_mask_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_STAND = 2'd1,
      PH_MOVE  = 2'd2
   } phase_type;

   localparam floor_type TOP_FLOOR = floor_type'(FLOORS - 1);

   // Seven-segment patterns for the digits 0 to 3.
   localparam logic [SEG_W-1:0] SEG_TABLE [FLOORS] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F
   };

   // Commands from the step logic to the request stack.
   typedef struct packed {
      logic           pop;
      floor_mask_type push_mask;
   } stack_cmd_type;

   typedef struct packed {
      floor_type         current_floor;
      floor_type         target_floor;
      logic              moving;
      logic              going_down;
      floor_mask_type    floor_lamps;
      floor_mask_type    target_lamps;
      logic [SEG_W-1:0]  display_segments;
      logic [PCOUNT_W-1:0] pending_count;
   } rsp_type;

   function automatic floor_mask_type floor_onehot(input floor_type fl);
      floor_onehot = floor_mask_type'(1) << fl;
   endfunction

endpackage

// File: rtl/efc_if.sv
`timescale 1ns / 1ps

interface efc_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] floor_sensors;
   logic [3:0] call_buttons;

   modport source (output valid, output floor_sensors, output call_buttons, input ready);
   modport sink   (input valid, input floor_sensors, input call_buttons, output ready);
endinterface

interface efc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] current_floor;
   logic [1:0] target_floor;
   logic       moving;
   logic       going_down;
   logic [3:0] floor_lamps;
   logic [3:0] target_lamps;
   logic [6:0] display_segments;
   logic [2:0] pending_count;

   modport source (output valid, output current_floor, output target_floor, output moving,
                   output going_down, output floor_lamps, output target_lamps,
                   output display_segments, output pending_count, input ready);
   modport sink   (input valid, input current_floor, input target_floor, input moving,
                   input going_down, input floor_lamps, input target_lamps,
                   input display_segments, input pending_count, output ready);
endinterface

// File: rtl/efc_stack.sv
`timescale 1ns / 1ps

module efc_stack #(
   parameter int unsigned DEPTH = efc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  efc_pkg::stack_cmd_type  cmd,
   output efc_pkg::floor_type      top_entry,
   output logic                    not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count_in
);
   import efc_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   floor_type       entries_ff [DEPTH];
   floor_type       entries_in [DEPTH];
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   top_index;

   assign not_empty = (count_ff != '0);
   assign top_index = count_ff - CW'(1);
   assign top_entry = entries_ff[top_index[IW-1:0]];

   // Pushes go in ascending floor order; each one lands on the next free
   // slot and is dropped once the stack is full.
   always_comb begin
      logic [CW-1:0] run;
      entries_in = entries_ff;
      run        = count_ff;
      if (cmd.pop && not_empty) begin
         run = count_ff - CW'(1);
      end
      for (int k = 0; k < FLOORS; k++) begin
         if (cmd.push_mask[k] && (run < CW'(DEPTH))) begin
            entries_in[run[IW-1:0]] = floor_type'(k);
            run = run + CW'(1);
         end
      end
      count_in = run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (enable) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entries_ff <= entries_in;
      end
   end

endmodule

// File: rtl/efc_step.sv
`timescale 1ns / 1ps

module efc_step #(
   parameter int unsigned CW = 3
) (
   input  efc_pkg::phase_type      phase,
   input  efc_pkg::floor_type      floor_now,
   input  efc_pkg::floor_type      floor_goal,
   input  efc_pkg::floor_mask_type sensors,
   input  efc_pkg::floor_mask_type buttons,
   input  efc_pkg::floor_type      stack_top,
   input  logic                    stack_not_empty,
   input  logic [CW-1:0]           count_next,
   output efc_pkg::phase_type      phase_next,
   output efc_pkg::floor_type      now_next,
   output efc_pkg::floor_type      goal_next,
   output efc_pkg::stack_cmd_type  cmd,
   output efc_pkg::rsp_type        result
);
   import efc_pkg::*;

   floor_mask_type others;
   logic           btn_found;
   floor_type      btn_floor;
   logic           mv;

   // Button choice while standing: from the top floor the highest lower
   // floor wins, otherwise the lowest floor other than the current one.
   always_comb begin
      others    = buttons & ~floor_onehot(floor_now);
      btn_found = 1'b0;
      btn_floor = '0;
      if (floor_now == TOP_FLOOR) begin
         for (int k = 0; k < FLOORS - 1; k++) begin
            if (others[k]) begin
               btn_found = 1'b1;
               btn_floor = floor_type'(k);
            end
         end
      end else begin
         for (int k = FLOORS - 1; k >= 0; k--) begin
            if (others[k]) begin
               btn_found = 1'b1;
               btn_floor = floor_type'(k);
            end
         end
      end
   end

   always_comb begin
      phase_next    = phase;
      now_next      = floor_now;
      goal_next     = floor_goal;
      cmd.pop       = 1'b0;
      cmd.push_mask = '0;
      case (phase)
         PH_START: begin
            phase_next = PH_STAND;
            now_next   = '0;
            for (int k = FLOORS - 1; k >= 0; k--) begin
               if (sensors[k]) begin
                  now_next = floor_type'(k);
               end
            end
         end
         PH_MOVE: begin
            cmd.push_mask = buttons & ~floor_onehot(floor_goal);
            if (sensors[floor_goal]) begin
               now_next   = floor_goal;
               phase_next = PH_STAND;
            end
         end
         default: begin
            phase_next = PH_STAND;
            cmd.pop    = stack_not_empty;
            // A popped request for the current floor is stale and falls
            // through to the button check.
            if (stack_not_empty && (stack_top != floor_now)) begin
               goal_next  = stack_top;
               phase_next = PH_MOVE;
            end else if (btn_found) begin
               goal_next  = btn_floor;
               phase_next = PH_MOVE;
            end
         end
      endcase
   end

   assign mv = (phase_next == PH_MOVE);

   always_comb begin
      result.current_floor    = now_next;
      result.target_floor     = mv ? goal_next : '0;
      result.moving           = mv;
      result.going_down       = mv && (goal_next < now_next);
      result.floor_lamps      = mv ? '0 : floor_onehot(now_next);
      result.target_lamps     = mv ? floor_onehot(goal_next) : '0;
      result.display_segments = SEG_TABLE[now_next];
      result.pending_count    = PCOUNT_W'(count_next);
   end

endmodule

// File: rtl/four_floor_elevator_controller.sv
`timescale 1ns / 1ps
// An accepted poll beat waits in the input register, then retires through the step
// logic into the result register, which presents it as the result beat.
// Throughput: one poll beat per cycle, held back only when the result beat stalls.
// The state update for a poll is a single registered pass through the step logic.
// Reset (synchronous, active high) returns the controller to its start phase,
// floor 0, no target and an empty request stack; stack entries are not cleared.

module four_floor_elevator_controller #(
   parameter int unsigned STACK_DEPTH = efc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   efc_req_if.sink         req,
   efc_rsp_if.source       rsp
);
   import efc_pkg::*;

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   // Input register: holds one poll beat until the step logic can retire it.
   logic           stage_valid_ff;
   floor_mask_type sensors_ff;
   floor_mask_type buttons_ff;

   // Controller state.
   phase_type      phase_ff;
   floor_type      now_ff;
   floor_type      goal_ff;

   // Result register.
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   phase_type      phase_in;
   floor_type      now_in;
   floor_type      goal_in;
   stack_cmd_type  cmd;
   rsp_type        rsp_in;
   floor_type      stack_top;
   logic           stack_not_empty;
   logic [CW-1:0]  count_in;
   logic           advance;

   // The staged poll retires into the result register whenever that register
   // is empty or its beat is being taken in this cycle. A new poll beat is
   // taken whenever the stage is empty or retiring, so beats flow back to back.
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req.ready) begin
         stage_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         sensors_ff <= req.floor_sensors;
         buttons_ff <= req.call_buttons;
      end
   end

   efc_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .cmd       (cmd),
      .top_entry (stack_top),
      .not_empty (stack_not_empty),
      .count_in  (count_in)
   );

   efc_step #(
      .CW (CW)
   ) u_step (
      .phase           (phase_ff),
      .floor_now       (now_ff),
      .floor_goal      (goal_ff),
      .sensors         (sensors_ff),
      .buttons         (buttons_ff),
      .stack_top       (stack_top),
      .stack_not_empty (stack_not_empty),
      .count_next      (count_in),
      .phase_next      (phase_in),
      .now_next        (now_in),
      .goal_next       (goal_in),
      .cmd             (cmd),
      .result          (rsp_in)
   );

   // State and the result beat move together, once per retired poll.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         now_ff       <= '0;
         goal_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            now_ff   <= now_in;
            goal_ff  <= goal_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.current_floor    = rsp_ff.current_floor;
   assign rsp.target_floor     = rsp_ff.target_floor;
   assign rsp.moving           = rsp_ff.moving;
   assign rsp.going_down       = rsp_ff.going_down;
   assign rsp.floor_lamps      = rsp_ff.floor_lamps;
   assign rsp.target_lamps     = rsp_ff.target_lamps;
   assign rsp.display_segments = rsp_ff.display_segments;
   assign rsp.pending_count    = rsp_ff.pending_count;

endmodule
